FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the flow counter datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: design/ifbc_pkg.sv
// ----------------------------------------------------------------------------
// ifbc_pkg
// Types and constants for the IPv4 flow byte counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifbc_pkg;

    localparam int          FLOW_ENTRIES_DEF = 128;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [47:0] TOTAL_MAX        = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_UPDATED = 2'd1,
        ST_ADDED   = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] eth_type;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] frame_length;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [6:0]  entry_index;
        logic [47:0] flow_bytes;
        logic [7:0]  entries_used;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic update;
        logic add;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_ipv4;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: design/ifbc_datapath.sv
// ----------------------------------------------------------------------------
// ifbc_datapath
// Flow table memory, scan counter, saturating byte adder and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ifbc_datapath
    import ifbc_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_data,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_out_item      o_out_data
);

    localparam int IdxW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CntW = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CntW-1:0] EntriesMax = CntW'(FLOW_ENTRIES);

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [47:0] total;
    } t_flow_entry;

    t_flow_entry     r_mem [FLOW_ENTRIES];
    t_flow_entry     r_rd_data;
    logic [IdxW-1:0] r_rd_idx;
    t_in_item        r_item;
    logic [CntW-1:0] r_scan;
    logic            r_dvalid;
    logic [CntW-1:0] r_used;
    t_status         r_res_status;
    logic [IdxW-1:0] r_res_idx;
    logic [47:0]     r_res_bytes;
    logic            r_out_valid;
    t_out_item       r_out_data;

    logic            match;
    logic            scan_more;
    logic            rd_en;
    logic            has_room;
    logic [48:0]     sum;
    logic [47:0]     upd_total;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    t_flow_entry     wr_data;
    logic [31:0]     idx_wide;
    logic [31:0]     used_wide;

    assign match = r_dvalid
                && (r_rd_data.src == r_item.src_addr)
                && (r_rd_data.dst == r_item.dst_addr);
    assign scan_more = r_scan < r_used;
    assign rd_en     = i_cmd.scan_step && scan_more && !match;
    assign has_room  = r_used < EntriesMax;
    assign sum       = {1'b0, r_rd_data.total} + 49'(r_item.frame_length);
    assign upd_total = sum[48] ? TOTAL_MAX : sum[47:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_data = '{src: r_item.src_addr, dst: r_item.dst_addr, total: upd_total};
        if (i_cmd.update) begin
            wr_en = 1'b1;
        end else if (i_cmd.add && has_room) begin
            wr_en         = 1'b1;
            wr_addr       = r_used[IdxW-1:0];
            wr_data.total = 48'(r_item.frame_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_scan[IdxW-1:0]];
            r_rd_idx  <= r_scan[IdxW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_dvalid    <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan   <= '0;
                r_dvalid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (rd_en) begin
                    r_scan <= r_scan + 1'b1;
                end
                r_dvalid <= rd_en || match;
            end
            if (i_cmd.add && has_room) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign idx_wide  = 32'(r_res_idx);
    assign used_wide = 32'(r_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item       <= i_in_data;
            r_res_status <= ST_IGNORED;
            r_res_idx    <= '0;
            r_res_bytes  <= '0;
        end else if (i_cmd.update) begin
            r_res_status <= ST_UPDATED;
            r_res_idx    <= r_rd_idx;
            r_res_bytes  <= upd_total;
        end else if (i_cmd.add) begin
            if (has_room) begin
                r_res_status <= ST_ADDED;
                r_res_idx    <= r_used[IdxW-1:0];
                r_res_bytes  <= 48'(r_item.frame_length);
            end else begin
                r_res_status <= ST_DROPPED;
                r_res_idx    <= '0;
                r_res_bytes  <= '0;
            end
        end
        if (i_cmd.emit) begin
            r_out_data.status       <= r_res_status;
            r_out_data.entry_index  <= idx_wide[6:0];
            r_out_data.flow_bytes   <= r_res_bytes;
            r_out_data.entries_used <= used_wide[7:0];
        end
    end

    assign o_stat.is_ipv4  = i_in_data.eth_type == ETHERTYPE_IPV4;
    assign o_stat.hit      = match;
    assign o_stat.scan_end = !scan_more && !r_dvalid;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_CLK(a_used_bound, r_used <= EntriesMax, "flow count above table size")
    `ASSERT_CLK(a_add_incr, (i_cmd.add && has_room) |=> (r_used == $past(r_used) + 1'b1),
                "append did not advance flow count")
    `ASSERT_CLK(a_update_data, i_cmd.update |-> r_dvalid, "update without read entry")

endmodule

`default_nettype wire

FILE: design/ifbc_ctrl.sv
// ----------------------------------------------------------------------------
// ifbc_ctrl
// Sequencer: request capture, table scan, update or append, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ifbc_ctrl
    import ifbc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.is_ipv4 ? S_SEARCH : S_DONE;
                end
            end
            S_SEARCH: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_UPDATE;
                end else if (i_stat.scan_end) begin
                    o_cmd.add = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ipv4_flow_byte_counter.sv
// A non-IPv4 request goes from acceptance straight to its result; an IPv4 request first
// scans the flows in use, then updates the hit entry or appends a new one on a miss.
// The table is scanned one entry per cycle through the single read port of the flow
// memory; the next request is taken the cycle after the result is registered.
// Reset clears the flow count and the handshake state; table contents are not cleared.
// ----------------------------------------------------------------------------
// ipv4_flow_byte_counter
// Per source/destination IPv4 byte accounting with a saturating flow table.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_flow_byte_counter
    import ifbc_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    ifbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ifbc_datapath #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: test/tb_ipv4_flow_byte_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_flow_byte_counter
// Self-checking bench for the per-flow IPv4 byte counter.
//
// A shadow flow table in the bench predicts every result as each request is
// accepted. A checker compares each returned result field by field, in order.
// The run starts with directed frames: EtherType corner values, address and
// length extremes, and swapped pairs. It then sends random traffic that mostly
// revisits known flows. A long receiver hold-off forces input backpressure.
// The table is then filled to capacity, and the full table is driven with
// hits, drops and non-IPv4 noise. Sender bursts and receiver stalls are
// random throughout.
// ----------------------------------------------------------------------------

module tb_ipv4_flow_byte_counter;
    import ifbc_pkg::*;

    localparam int TABLE_DEPTH  = FLOW_ENTRIES_DEF;
    localparam int TAIL_CYCLES  = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_LIMIT = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    // shadow flow table
    logic [31:0] flow_src_copy   [TABLE_DEPTH];
    logic [31:0] flow_dst_copy   [TABLE_DEPTH];
    logic [47:0] flow_bytes_copy [TABLE_DEPTH];
    int          flows_in_use = 0;

    t_out_item pending_results [$];
    t_out_item want;

    int requests_sent   = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int ignored_count   = 0;
    int updated_count   = 0;
    int added_count     = 0;
    int dropped_count   = 0;
    int cycle_count     = 0;

    int burst_left       = 0;
    int hold_off_request = 0;
    int hold_off_left    = 0;
    int pattern_left     = 0;
    logic [15:0] ready_pattern = '1;

    ipv4_flow_byte_counter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic t_out_item predict_flow(input t_in_item req);
        t_out_item   res;
        int          hit;
        logic [48:0] sum;
        res = '0;
        hit = -1;
        if (req.eth_type != ETHERTYPE_IPV4) begin
            res.status = ST_IGNORED;
            ignored_count++;
        end else begin
            for (int i = 0; i < flows_in_use; i++) begin
                if (hit < 0 && flow_src_copy[i] == req.src_addr &&
                    flow_dst_copy[i] == req.dst_addr) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                sum = {1'b0, flow_bytes_copy[hit]} + req.frame_length;
                flow_bytes_copy[hit] = sum[48] ? TOTAL_MAX : sum[47:0];
                res.status      = ST_UPDATED;
                res.entry_index = hit[6:0];
                res.flow_bytes  = flow_bytes_copy[hit];
                updated_count++;
            end else if (flows_in_use < TABLE_DEPTH) begin
                flow_src_copy[flows_in_use]   = req.src_addr;
                flow_dst_copy[flows_in_use]   = req.dst_addr;
                flow_bytes_copy[flows_in_use] = {32'd0, req.frame_length};
                res.status      = ST_ADDED;
                res.entry_index = flows_in_use[6:0];
                res.flow_bytes  = {32'd0, req.frame_length};
                flows_in_use++;
                added_count++;
            end else begin
                res.status = ST_DROPPED;
                dropped_count++;
            end
        end
        res.entries_used = flows_in_use[7:0];
        return res;
    endfunction

    function automatic logic [15:0] random_length();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(60, 1518));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly known flows; new_pct sets how often a fresh pair is offered
    function automatic t_in_item random_frame(input int new_pct);
        t_in_item req;
        int       pick;
        int       k;
        pick = $urandom_range(0, 99);
        k    = (flows_in_use > 0) ? $urandom_range(0, flows_in_use - 1) : 0;
        req  = t_in_item'{ETHERTYPE_IPV4, 32'($urandom), 32'($urandom), random_length()};
        if (pick < 8) begin
            req.eth_type = 16'($urandom);
            if (req.eth_type == ETHERTYPE_IPV4) begin
                req.eth_type = ~ETHERTYPE_IPV4;
            end
        end else if (flows_in_use == 0 || pick < 8 + new_pct) begin
            // fresh random pair
        end else if (pick < 14 + new_pct) begin
            // near miss: swapped pair or one flipped address bit
            if ($urandom_range(0, 1) == 0) begin
                req.src_addr = flow_dst_copy[k];
                req.dst_addr = flow_src_copy[k];
            end else begin
                req.src_addr = flow_src_copy[k];
                req.dst_addr = flow_dst_copy[k] ^ (32'd1 << $urandom_range(0, 31));
            end
        end else begin
            req.src_addr = flow_src_copy[k];
            req.dst_addr = flow_dst_copy[k];
        end
        return req;
    endfunction

    // entered and left at a falling edge
    task automatic send_request(input t_in_item req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_flow(req));
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_directed();
        send_request(t_in_item'{16'h0000, 32'h0000_0000, 32'h0000_0000, 16'd0});
        send_request(t_in_item'{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        send_request(t_in_item'{16'h0801, 32'h0000_0000, 32'h0000_0000, 16'd64});
        send_request(t_in_item'{16'h8000, 32'h0000_0000, 32'h0000_0000, 16'd64});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'h0000_0000, 32'h0000_0000, 16'd0});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'h0000_0000, 32'h0000_0000, 16'hFFFF});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'h0000_0000, 32'hFFFF_FFFF, 16'd1});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'h0000_0000, 16'd1});
        // known pair under a foreign EtherType must not count
        send_request(t_in_item'{16'h86DD, 32'h0000_0000, 32'h0000_0000, 16'hFFFF});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'h0000_0000, 32'h0000_0000, 16'd0});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'hC0A8_0001, 32'hC0A8_0002, 16'd1518});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'hC0A8_0001, 32'hC0A8_0002, 16'd60});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'hC0A8_0002, 32'hC0A8_0001, 16'd60});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF});
        send_request(t_in_item'{16'h0008, 32'hC0A8_0001, 32'hC0A8_0002, 16'd60});
        wait_drained();
    endtask

    task automatic test_flow_mix();
        repeat (540) send_request(random_frame(12));
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off_request = 400;
        repeat (40) send_request(random_frame(10));
        wait_drained();
    endtask

    task automatic test_table_full();
        while (flows_in_use < TABLE_DEPTH) begin
            send_request(t_in_item'{ETHERTYPE_IPV4, 32'($urandom), 32'($urandom),
                                    random_length()});
        end
        send_request(t_in_item'{ETHERTYPE_IPV4, flow_src_copy[TABLE_DEPTH - 1],
                                flow_dst_copy[TABLE_DEPTH - 1], 16'hFFFF});
        send_request(t_in_item'{ETHERTYPE_IPV4, flow_src_copy[0], flow_dst_copy[0], 16'd1});
        send_request(t_in_item'{ETHERTYPE_IPV4, 32'h0A00_0001, 32'h0A00_0002, 16'hFFFF});
        send_request(t_in_item'{ETHERTYPE_IPV4, flow_src_copy[5], ~flow_dst_copy[5], 16'd0});
        send_request(t_in_item'{16'hFFFF, flow_src_copy[0], flow_dst_copy[0], 16'd100});
        send_request(t_in_item'{ETHERTYPE_IPV4, flow_src_copy[TABLE_DEPTH - 1],
                                flow_dst_copy[TABLE_DEPTH - 1], 16'd0});
        wait_drained();
    endtask

    task automatic test_full_table_mix();
        repeat (580) send_request(random_frame(15));
        wait_drained();
    endtask

    task automatic report_field(input string field, input logic [63:0] exp_val,
                                input logic [63:0] act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                     results_checked, field, exp_val, act_val);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("result with no request pending: 0x%0h", out_data);
                end
            end else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_field("status", want.status, out_data.status);
                if (out_data.entry_index !== want.entry_index)
                    report_field("entry_index", want.entry_index, out_data.entry_index);
                if (out_data.flow_bytes !== want.flow_bytes)
                    report_field("flow_bytes", want.flow_bytes, out_data.flow_bytes);
                if (out_data.entries_used !== want.entries_used)
                    report_field("entries_used", want.entries_used, out_data.entries_used);
            end
            results_checked++;
        end
    end

    always @(negedge clk) begin
        if (hold_off_request != 0) begin
            hold_off_left    = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom);
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
                pattern_left = $urandom_range(16, 64);
            end
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_left--;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_flow_mix();
        test_backpressure();
        test_table_full();
        test_full_table_mix();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("%0d requests, %0d results: %0d added, %0d updated, %0d dropped, %0d ignored",
                 requests_sent, results_checked, added_count, updated_count,
                 dropped_count, ignored_count);
        $display("table filled to %0d of %0d entries, %0d mismatches",
                 flows_in_use, TABLE_DEPTH, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
